>>> rtl/ipv6ehw_pkg.sv
`timescale 1ns / 1ps
// ipv6ehw_pkg: shared types and constants of the ipv6 extension header walker
// header kinds, walker control state, result word; no dependencies

package ipv6ehw_pkg;

	typedef enum logic [2:0] {
		KIND_OUTER    = 3'd0,
		KIND_NESTED   = 3'd1,
		KIND_EXT8     = 3'd2,
		KIND_AH       = 3'd3,
		KIND_FRAG     = 3'd4,
		KIND_UPPER    = 3'd5,
		KIND_NONFIRST = 3'd6,
		KIND_ERROR    = 3'd7
	} kind_t;

	localparam logic [7:0] PROTO_HOPOPT = 8'd0;
	localparam logic [7:0] PROTO_IPV6   = 8'd41;
	localparam logic [7:0] PROTO_ROUTE  = 8'd43;
	localparam logic [7:0] PROTO_FRAG   = 8'd44;
	localparam logic [7:0] PROTO_AH     = 8'd51;
	localparam logic [7:0] PROTO_DSTOPT = 8'd60;
	localparam logic [7:0] PROTO_NONE   = 8'd255;

	localparam logic [1:0] ST_UPPER    = 2'd0;
	localparam logic [1:0] ST_NONFIRST = 2'd1;
	localparam logic [1:0] ST_ERROR    = 2'd2;

	localparam logic [15:0] OUTER_FIELD_OFS = 16'd6;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  proto;
		logic [15:0] lfo;
		logic        frag;
		logic [7:0]  link;
		logic        done;
	} ctrl_t;

	typedef struct packed {
		logic [7:0]  proto;
		logic [15:0] payload_ofs;
		logic [15:0] field_ofs;
		logic [1:0]  status;
	} result_t;

endpackage

>>> rtl/ipv6ehw_step.sv
`timescale 1ns / 1ps
// ipv6ehw_step: next-state and result logic for one packet word
// depends on ipv6ehw_pkg

module ipv6ehw_step #(
	parameter int OFFSET_BITS = 16
) (
	input  logic [7:0]            pbyte,
	input  logic                  first,
	input  logic                  last,
	input  logic [7:0]            link_len,
	input  logic [OFFSET_BITS:0]  pos,
	input  logic [OFFSET_BITS-1:0] hstart,
	input  ipv6ehw_pkg::ctrl_t    ctrl,
	output logic [OFFSET_BITS:0]  pos_nxt,
	output logic [OFFSET_BITS-1:0] hstart_nxt,
	output ipv6ehw_pkg::ctrl_t    ctrl_nxt,
	output ipv6ehw_pkg::result_t  res
);
	import ipv6ehw_pkg::*;

	localparam int PW = OFFSET_BITS + 1;
	localparam int NW = OFFSET_BITS + 2;
	localparam int LW = 12;
	localparam logic [NW-1:0] OFF_LIMIT = NW'((1 << OFFSET_BITS) - 1);
	localparam logic [PW-1:0] POS_MAX = '1;

	logic          start;
	logic [PW-1:0] p;
	logic [PW-1:0] rel;
	logic [OFFSET_BITS-1:0] hs;
	logic [NW-1:0] next_hs;
	logic [NW-1:0] link_sum;
	logic [LW-1:0] len;
	logic          adv;
	ctrl_t         c;

	always_comb begin
		start = first || (pos == '0);
		p = start ? '0 : pos;
		hs = start ? '0 : hstart;
		c = ctrl;
		if (start) begin
			c.kind = KIND_OUTER;
			c.proto = '0;
			c.lfo = OUTER_FIELD_OFS;
			c.frag = 1'b0;
			c.link = link_len;
			c.done = 1'b0;
		end
		rel = p - PW'(hs);
		adv = 1'b0;
		len = '0;
		if (!c.done && (p >= PW'(hs))) begin
			unique case (c.kind)
				KIND_OUTER, KIND_NESTED: begin
					if (rel == PW'(6)) begin
						c.proto = pbyte;
					end else if (rel == PW'(39)) begin
						adv = 1'b1;
						len = LW'(40);
					end
				end
				KIND_EXT8: begin
					if (rel == '0) begin
						c.proto = pbyte;
					end else if (rel == PW'(1)) begin
						adv = 1'b1;
						len = LW'({1'b0, pbyte} + 9'd1) << 3;
					end
				end
				KIND_AH: begin
					if (rel == '0) begin
						c.proto = pbyte;
					end else if (rel == PW'(1)) begin
						adv = 1'b1;
						len = LW'({1'b0, pbyte} + 9'd2) << 2;
					end
				end
				KIND_FRAG: begin
					if (rel == '0) begin
						c.proto = pbyte;
					end else if (rel == PW'(2)) begin
						c.frag = (pbyte != 8'd0);
					end else if (rel == PW'(3)) begin
						c.frag = c.frag || (pbyte[7:3] != 5'd0);
					end else if (rel == PW'(7)) begin
						if (c.frag) begin
							c.kind = KIND_NONFIRST;
							c.proto = PROTO_FRAG;
							c.done = 1'b1;
						end else begin
							adv = 1'b1;
							len = LW'(8);
						end
					end
				end
				default: begin
					c.done = 1'b1;
				end
			endcase
		end
		next_hs = NW'(hs) + NW'(len);
		link_sum = NW'(c.link) + next_hs;
		if (adv) begin
			if (link_sum > OFF_LIMIT) begin
				c.kind = KIND_ERROR;
				c.done = 1'b1;
			end else begin
				hs = next_hs[OFFSET_BITS-1:0];
				unique case (c.proto)
					PROTO_IPV6: begin
						c.kind = KIND_NESTED;
						c.lfo = 16'(next_hs + NW'(6));
					end
					PROTO_AH: begin
						c.kind = KIND_AH;
						c.lfo = 16'(next_hs);
					end
					PROTO_FRAG: begin
						c.kind = KIND_FRAG;
						c.lfo = 16'(next_hs);
					end
					PROTO_HOPOPT, PROTO_ROUTE, PROTO_DSTOPT: begin
						c.kind = KIND_EXT8;
						c.lfo = 16'(next_hs);
					end
					default: begin
						c.kind = KIND_UPPER;
						c.done = 1'b1;
					end
				endcase
			end
		end

		if (last) begin
			pos_nxt = '0;
		end else if (p == POS_MAX) begin
			pos_nxt = p;
		end else begin
			pos_nxt = p + PW'(1);
		end
		hstart_nxt = hs;
		ctrl_nxt = c;

		if (c.done && (c.kind == KIND_UPPER || c.kind == KIND_NONFIRST)) begin
			res.proto = c.proto;
			res.payload_ofs = 16'(NW'(c.link) + NW'(hs));
			res.field_ofs = c.lfo;
			res.status = (c.kind == KIND_UPPER) ? ST_UPPER : ST_NONFIRST;
		end else begin
			res.proto = PROTO_NONE;
			res.payload_ofs = '0;
			res.field_ofs = '0;
			res.status = ST_ERROR;
		end
	end

endmodule

>>> rtl/ipv6_extension_header_walker_top.sv
`timescale 1ns / 1ps
// channel   | handshake                     | payload
// packet    | packet_valid / packet_ready   | packet_byte, first_of_packet,
//           |                               | last_of_packet, link_header_length
// result    | result_valid / result_ready   | next_protocol, payload_offset,
//           |                               | next_field_offset, status
// one packet word per cycle, unless a packet's last word waits on a stalled result;
// a word is held in the input register, its walk step updates the chain state, and
// the last word of a packet loads the result register and sets result_valid with it.
// reset clears the chain state and both valid flags, no clearing pass.
// a stalled result holds only words that end a packet; other words flow on.
// depends on ipv6ehw_pkg and ipv6ehw_step

module ipv6_extension_header_walker_top #(
	parameter int OFFSET_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        packet_valid,
	output logic        packet_ready,
	input  logic [7:0]  packet_byte,
	input  logic        first_of_packet,
	input  logic        last_of_packet,
	input  logic [7:0]  link_header_length,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [7:0]  next_protocol,
	output logic [15:0] payload_offset,
	output logic [15:0] next_field_offset,
	output logic [1:0]  status
);
	import ipv6ehw_pkg::*;

	logic [7:0] byte_s1;
	logic       first_s1;
	logic       last_s1;
	logic [7:0] link_s1;
	logic       valid_s1;

	logic [OFFSET_BITS:0]   pos_q;
	logic [OFFSET_BITS-1:0] hstart_q;
	ctrl_t                  ctrl_q;

	logic [OFFSET_BITS:0]   pos_nxt;
	logic [OFFSET_BITS-1:0] hstart_nxt;
	ctrl_t                  ctrl_nxt;
	result_t                res;
	result_t                res_q;
	logic                   out_valid_q;
	logic                   go;

	assign go = valid_s1 && (!last_s1 || !out_valid_q || result_ready);
	assign packet_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (packet_ready) begin
			valid_s1 <= packet_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (packet_ready && packet_valid) begin
			byte_s1 <= packet_byte;
			first_s1 <= first_of_packet;
			last_s1 <= last_of_packet;
			link_s1 <= link_header_length;
		end
	end

	ipv6ehw_step #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_step (
		.pbyte     (byte_s1),
		.first     (first_s1),
		.last      (last_s1),
		.link_len  (link_s1),
		.pos       (pos_q),
		.hstart    (hstart_q),
		.ctrl      (ctrl_q),
		.pos_nxt   (pos_nxt),
		.hstart_nxt(hstart_nxt),
		.ctrl_nxt  (ctrl_nxt),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			hstart_q <= '0;
			ctrl_q <= '{kind: KIND_OUTER, proto: 8'd0, lfo: OUTER_FIELD_OFS,
				frag: 1'b0, link: 8'd0, done: 1'b0};
		end else if (go) begin
			pos_q <= pos_nxt;
			hstart_q <= hstart_nxt;
			ctrl_q <= ctrl_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && last_s1) begin
			res_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign next_protocol = res_q.proto;
	assign payload_offset = res_q.payload_ofs;
	assign next_field_offset = res_q.field_ofs;
	assign status = res_q.status;

	a_last_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		go && last_s1 |=> result_valid)
		else $error("packet end did not load a result");

	a_error_word: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == ST_ERROR |->
		next_protocol == PROTO_NONE && payload_offset == 16'd0 &&
		next_field_offset == 16'd0)
		else $error("error result carries chain data");

	a_end_kind_done: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_q.kind == KIND_UPPER || ctrl_q.kind == KIND_NONFIRST ||
		ctrl_q.kind == KIND_ERROR |-> ctrl_q.done)
		else $error("walk ended without done flag");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> status == ST_UPPER || status == ST_NONFIRST ||
		status == ST_ERROR)
		else $error("undefined status code");

endmodule
